// ===== rtl/cwpc_pkg.sv =====
// Shared types and constants for the cache write port controller.
package cwpc_pkg;

  localparam int TAG_WORD_W  = 32;
  localparam int TAG_WIDTH_DEF = 32;

  localparam int REQ_FLAGS_W = 4;
  localparam int CACHE_OP_W  = 2;
  localparam int BANK_SEL_W  = 2;
  localparam int TRAP_W      = 2;
  localparam int LINES_W     = 5;
  localparam int BUS_STAT_W  = 2;
  localparam int BUS_OP_W    = 3;
  localparam int STATE_W     = 5;

  // request_flags bits
  localparam int RF_WRITE  = 0;
  localparam int RF_DIRECT = 1;
  localparam int RF_SCOND  = 2;
  localparam int RF_SCOK   = 3;

  // grant / request line bits
  localparam int LN_LOCK = 0;
  localparam int LN_TAGR = 1;
  localparam int LN_TAGW = 2;
  localparam int LN_BANK = 3;
  localparam int LN_BUS  = 4;

  // tag word bits
  localparam int TB_VALID = 0;
  localparam int TB_DIRTY = 1;
  localparam int TB_WRITE = 2;
  localparam int TB_USER  = 3;

  // trap_flags bits
  localparam int TR_USER    = 0;
  localparam int TR_NONUSER = 1;

  // bus_status bits
  localparam int BS_BUSY = 0;
  localparam int BS_WOK  = 1;

  // bus operation codes
  localparam logic [BUS_OP_W-1:0] BOP_NONE    = 3'd0;
  localparam logic [BUS_OP_W-1:0] BOP_DIRECT  = 3'd1;
  localparam logic [BUS_OP_W-1:0] BOP_REPLACE = 3'd2;
  localparam logic [BUS_OP_W-1:0] BOP_SP_OFS  = 3'd2;

  localparam logic [CACHE_OP_W-1:0] COP_NONE = 2'd0;

  typedef struct packed {
    logic [REQ_FLAGS_W-1:0] request_flags;
    logic [CACHE_OP_W-1:0]  cache_op;
    logic [BANK_SEL_W-1:0]  bank_select;
    logic [TRAP_W-1:0]      trap_flags;
    logic [TAG_WORD_W-1:0]  tag_word_in;
    logic [LINES_W-1:0]     grant_flags;
    logic [BUS_STAT_W-1:0]  bus_status;
  } cwpc_item_t;

  typedef struct packed {
    logic                  write_ack;
    logic                  port_write_ok;
    logic [BUS_OP_W-1:0]   bus_operation;
    logic [LINES_W-1:0]    request_lines;
    logic                  tag_write;
    logic                  bank_write;
    logic [TAG_WORD_W-1:0] tag_word_out;
    logic [STATE_W-1:0]    state_code;
  } cwpc_result_t;

endpackage

// ===== rtl/cwpc_intf.sv =====
// Valid/ready channel interfaces for sampled port beats and result beats.
interface cwpc_in_if
  import cwpc_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic [REQ_FLAGS_W-1:0] request_flags;
  logic [CACHE_OP_W-1:0]  cache_op;
  logic [BANK_SEL_W-1:0]  bank_select;
  logic [TRAP_W-1:0]      trap_flags;
  logic [TAG_WORD_W-1:0]  tag_word_in;
  logic [LINES_W-1:0]     grant_flags;
  logic [BUS_STAT_W-1:0]  bus_status;

  modport source (
    output valid, request_flags, cache_op, bank_select, trap_flags,
           tag_word_in, grant_flags, bus_status,
    input  ready
  );
  modport sink (
    input  valid, request_flags, cache_op, bank_select, trap_flags,
           tag_word_in, grant_flags, bus_status,
    output ready
  );
endinterface

interface cwpc_out_if
  import cwpc_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic                  write_ack;
  logic                  port_write_ok;
  logic [BUS_OP_W-1:0]   bus_operation;
  logic [LINES_W-1:0]    request_lines;
  logic                  tag_write;
  logic                  bank_write;
  logic [TAG_WORD_W-1:0] tag_word_out;
  logic [STATE_W-1:0]    state_code;

  modport source (
    output valid, write_ack, port_write_ok, bus_operation, request_lines,
           tag_write, bank_write, tag_word_out, state_code,
    input  ready
  );
  modport sink (
    input  valid, write_ack, port_write_ok, bus_operation, request_lines,
           tag_write, bank_write, tag_word_out, state_code,
    output ready
  );
endinterface

// ===== rtl/cache_write_port_controller_unit.sv =====
// Top level of the cache write port controller.
// Path: each beat passes through the input register, then the state machine, then the result register.
// Throughput: one beat per cycle while the result register has room; each beat is one step of the state machine.
// The state register and held tag advance only when a beat moves into the result register.
// Reset: state idle, held tag zero, input and result registers empty.
module cache_write_port_controller_unit
  import cwpc_pkg::*;
#(
  parameter int TAG_WIDTH = TAG_WIDTH_DEF
)(
  input  logic       clk,
  input  logic       rst_n,
  cwpc_in_if.sink    in_ch,
  cwpc_out_if.source out_ch
);

  logic         item_valid;
  logic         room;
  logic         advance;
  cwpc_item_t   item;
  cwpc_result_t res;

  assign advance = item_valid && room;

  cwpc_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  cwpc_fsm #(
    .TAG_WIDTH (TAG_WIDTH)
  ) u_fsm (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .item    (item),
    .res     (res)
  );

  cwpc_out_stage u_out (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .res     (res),
    .room    (room),
    .out_ch  (out_ch)
  );

endmodule

// ===== rtl/cwpc_in_stage.sv =====
// Input register stage: captures one sampled beat per cycle while its ready is high.
module cwpc_in_stage
  import cwpc_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  cwpc_in_if.sink        in_ch,
  input  logic           advance,
  output logic           item_valid,
  output cwpc_item_t     item
);

  logic       valid_r;
  cwpc_item_t item_r;

  assign in_ch.ready = !valid_r || advance;
  assign item_valid  = valid_r;
  assign item        = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_r.request_flags <= in_ch.request_flags;
      item_r.cache_op      <= in_ch.cache_op;
      item_r.bank_select   <= in_ch.bank_select;
      item_r.trap_flags    <= in_ch.trap_flags;
      item_r.tag_word_in   <= in_ch.tag_word_in;
      item_r.grant_flags   <= in_ch.grant_flags;
      item_r.bus_status    <= in_ch.bus_status;
    end
  end

endmodule

// ===== rtl/cwpc_fsm.sv =====
// Write port state machine: one step per beat, Mealy outputs, held tag.
module cwpc_fsm
  import cwpc_pkg::*;
#(
  parameter int TAG_WIDTH = TAG_WIDTH_DEF
)(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         step_en,
  input  cwpc_item_t   item,
  output cwpc_result_t res
);

  localparam int HeldW = (TAG_WIDTH < TAG_WORD_W) ? TAG_WIDTH : TAG_WORD_W;

  typedef enum logic [STATE_W-1:0] {
    ST_IDLE         = 5'd0,
    ST_DIRECT       = 5'd1,
    ST_RELEASE      = 5'd2,
    ST_READ         = 5'd3,
    ST_WR_BOTH      = 5'd4,
    ST_WR_TAG       = 5'd5,
    ST_WR_BANK      = 5'd6,
    ST_MISS_ARB     = 5'd7,
    ST_MISS_RELEASE = 5'd8,
    ST_MISS_TAGREQ  = 5'd9,
    ST_MISS_READ    = 5'd10,
    ST_REPLACE      = 5'd11,
    ST_REPLACE_WAIT = 5'd12,
    ST_SP_RELEASE   = 5'd13,
    ST_SP_START     = 5'd14,
    ST_SP_WAIT      = 5'd15,
    ST_FAULT        = 5'd16
  } state_t;

  state_t             state_r, state_nxt;
  logic [HeldW-1:0]   held_r, held_nxt;
  logic [HeldW-1:0]   tin;
  logic [HeldW-1:0]   held_dirty;
  logic               wr, direct, scond, scok, busy;
  logic [LINES_W-1:0] g;

  function automatic state_t judge_tag(input logic [HeldW-1:0] t,
                                       input logic [TRAP_W-1:0] trap,
                                       input state_t miss_state);
    logic trapped;
    trapped = t[TB_USER] ? trap[TR_USER] : trap[TR_NONUSER];
    if (!t[TB_VALID]) begin
      return miss_state;
    end else if (!t[TB_WRITE] || trapped) begin
      return ST_FAULT;
    end else if (t[TB_DIRTY]) begin
      return ST_WR_BANK;
    end else begin
      return ST_WR_BOTH;
    end
  endfunction

  assign tin        = item.tag_word_in[HeldW-1:0];
  assign held_dirty = held_r | HeldW'(1 << TB_DIRTY);
  assign wr         = item.request_flags[RF_WRITE];
  assign direct     = item.request_flags[RF_DIRECT];
  assign scond      = item.request_flags[RF_SCOND];
  assign scok       = item.request_flags[RF_SCOK];
  assign busy       = item.bus_status[BS_BUSY];
  assign g          = item.grant_flags;

  always_comb begin
    res               = '0;
    res.bus_operation = BOP_NONE;
    res.tag_word_out  = TAG_WORD_W'(held_r);
    res.state_code    = state_r;
    state_nxt         = state_r;
    held_nxt          = held_r;
    unique case (state_r)
      ST_IDLE: begin
        if (wr) begin
          if (direct) begin
            res.request_lines[LN_BUS] = 1'b1;
            res.bus_operation         = BOP_DIRECT;
            if (g[LN_BUS] && !busy) state_nxt = ST_DIRECT;
          end else if (scond && !scok) begin
            res.write_ack = 1'b1;
          end else begin
            res.request_lines[LN_LOCK] = 1'b1;
            res.request_lines[LN_TAGR] = 1'b1;
            if (g[LN_TAGR]) state_nxt = g[LN_LOCK] ? ST_READ : ST_RELEASE;
          end
        end else if (item.cache_op != COP_NONE) begin
          res.request_lines[LN_BUS]  = 1'b1;
          res.request_lines[LN_LOCK] = 1'b1;
          if (g[LN_LOCK] && !g[LN_BUS]) state_nxt = ST_SP_RELEASE;
          if (g[LN_BUS] && !busy) state_nxt = ST_SP_START;
        end
      end
      ST_DIRECT: begin
        res.request_lines[LN_BUS] = 1'b1;
        res.bus_operation         = BOP_DIRECT;
        res.port_write_ok         = item.bus_status[BS_WOK];
        if (busy) begin
          res.write_ack = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_RELEASE: begin
        res.request_lines[LN_LOCK] = 1'b1;
        if (g[LN_LOCK]) state_nxt = ST_IDLE;
      end
      ST_READ: begin
        res.request_lines[LN_LOCK] = 1'b1;
        res.request_lines[LN_TAGR] = 1'b1;
        res.tag_word_out           = TAG_WORD_W'(tin);
        held_nxt                   = tin;
        state_nxt                  = judge_tag(tin, item.trap_flags, ST_MISS_ARB);
      end
      ST_WR_BOTH: begin
        res.request_lines[LN_LOCK] = 1'b1;
        res.request_lines[LN_TAGW] = 1'b1;
        res.request_lines[LN_BANK] = 1'b1;
        res.tag_word_out           = TAG_WORD_W'(held_dirty);
        if (g[LN_BANK]) begin
          res.bank_write = 1'b1;
          state_nxt      = ST_WR_TAG;
        end
        if (g[LN_TAGW]) begin
          res.tag_write = 1'b1;
          state_nxt     = ST_WR_BANK;
        end
        if (g[LN_BANK] && g[LN_TAGW]) begin
          res.write_ack     = 1'b1;
          res.port_write_ok = 1'b1;
          state_nxt         = ST_IDLE;
        end
      end
      ST_WR_TAG: begin
        res.request_lines[LN_LOCK] = 1'b1;
        res.request_lines[LN_TAGW] = 1'b1;
        res.tag_word_out           = TAG_WORD_W'(held_dirty);
        if (g[LN_TAGW]) begin
          res.tag_write     = 1'b1;
          res.write_ack     = 1'b1;
          res.port_write_ok = 1'b1;
          state_nxt         = ST_IDLE;
        end
      end
      ST_WR_BANK: begin
        res.request_lines[LN_LOCK] = 1'b1;
        res.request_lines[LN_BANK] = 1'b1;
        res.bank_write             = 1'b1;
        if (g[LN_BANK]) begin
          res.write_ack     = 1'b1;
          res.port_write_ok = 1'b1;
          state_nxt         = ST_IDLE;
        end
      end
      ST_MISS_ARB: begin
        res.request_lines[LN_BUS]  = 1'b1;
        res.request_lines[LN_LOCK] = 1'b1;
        if (g[LN_BUS] && !busy && g[LN_LOCK]) begin
          state_nxt = ST_MISS_TAGREQ;
        end else if (!g[LN_BUS] && g[LN_LOCK]) begin
          state_nxt = ST_MISS_RELEASE;
        end
      end
      ST_MISS_RELEASE: begin
        res.request_lines[LN_BUS] = 1'b1;
        if (g[LN_BUS]) state_nxt = ST_MISS_ARB;
      end
      ST_MISS_TAGREQ: begin
        res.request_lines[LN_BUS]  = 1'b1;
        res.request_lines[LN_LOCK] = 1'b1;
        res.request_lines[LN_TAGR] = 1'b1;
        if (g[LN_TAGR]) state_nxt = ST_MISS_READ;
      end
      ST_MISS_READ: begin
        res.request_lines[LN_BUS]  = 1'b1;
        res.request_lines[LN_LOCK] = 1'b1;
        res.request_lines[LN_TAGR] = 1'b1;
        held_nxt                   = tin;
        state_nxt                  = judge_tag(tin, item.trap_flags, ST_REPLACE);
      end
      ST_REPLACE: begin
        res.request_lines[LN_BUS]  = 1'b1;
        res.request_lines[LN_LOCK] = 1'b1;
        res.bus_operation          = BOP_REPLACE;
        if (busy) state_nxt = ST_REPLACE_WAIT;
      end
      ST_REPLACE_WAIT: begin
        res.request_lines[LN_BUS]  = 1'b1;
        res.request_lines[LN_LOCK] = 1'b1;
        if (!busy) begin
          res.request_lines[LN_TAGR] = 1'b1;
          state_nxt = g[LN_TAGR] ? ST_READ : ST_IDLE;
        end
      end
      ST_SP_RELEASE: begin
        res.request_lines[LN_BUS] = 1'b1;
        if (g[LN_BUS]) state_nxt = ST_IDLE;
      end
      ST_SP_START: begin
        res.request_lines[LN_BUS]  = 1'b1;
        res.request_lines[LN_LOCK] = 1'b1;
        if (item.cache_op != COP_NONE) begin
          res.bus_operation = {1'b0, item.cache_op} + BOP_SP_OFS;
        end
        if (busy) state_nxt = ST_SP_WAIT;
      end
      ST_SP_WAIT: begin
        res.request_lines[LN_BUS]  = 1'b1;
        res.request_lines[LN_LOCK] = 1'b1;
        if (!busy) begin
          res.write_ack     = 1'b1;
          res.port_write_ok = 1'b1;
          state_nxt         = ST_IDLE;
        end
      end
      ST_FAULT: begin
        res.write_ack = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      held_r  <= '0;
    end else if (step_en) begin
      state_r <= state_nxt;
      held_r  <= held_nxt;
    end
  end

  a_ack_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && res.write_ack |=> state_r == ST_IDLE)
    else $error("acknowledge did not return to idle");

  a_hold_state: assert property (@(posedge clk) disable iff (!rst_n)
    !step_en |=> $stable(state_r) && $stable(held_r))
    else $error("state moved without a beat");

  a_tag_write_dirty: assert property (@(posedge clk) disable iff (!rst_n)
    res.tag_write |-> res.tag_word_out[TB_DIRTY])
    else $error("tag written without dirty bit");

  a_bank_write_state: assert property (@(posedge clk) disable iff (!rst_n)
    res.bank_write |-> (state_r == ST_WR_BOTH || state_r == ST_WR_BANK))
    else $error("bank strobe outside write states");

endmodule

// ===== rtl/cwpc_out_stage.sv =====
// Result register stage: holds one result beat until it is taken.
module cwpc_out_stage
  import cwpc_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          advance,
  input  cwpc_result_t  res,
  output logic          room,
  cwpc_out_if.source    out_ch
);

  logic         valid_r;
  cwpc_result_t res_r;

  assign room = !valid_r || out_ch.ready;

  assign out_ch.valid         = valid_r;
  assign out_ch.write_ack     = res_r.write_ack;
  assign out_ch.port_write_ok = res_r.port_write_ok;
  assign out_ch.bus_operation = res_r.bus_operation;
  assign out_ch.request_lines = res_r.request_lines;
  assign out_ch.tag_write     = res_r.tag_write;
  assign out_ch.bank_write    = res_r.bank_write;
  assign out_ch.tag_word_out  = res_r.tag_word_out;
  assign out_ch.state_code    = res_r.state_code;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (room) begin
      valid_r <= advance;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

endmodule
